/* sv/wfd_pkg.sv */
// Package for the windowed FIR decimator: constants, codes, state and command types.
// Used by the interfaces wfd_out_if and wfd_cfg_if and by every module of the block; depends on nothing.
package wfd_pkg;

	localparam int MAX_TAPS_DEF    = 256;
	localparam int SAMPLE_BITS_DEF = 8;

	localparam int SHAPE_W   = 2;
	localparam int TAPS_W    = 9;
	localparam int DECIM_W   = 11;
	localparam int PHASE_W   = 10;
	localparam int DECIM_MAX = 1024;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam int WT_W      = 16;
	localparam int ACC_W     = 40;
	localparam int TOT_W     = 32;
	localparam int FRAC_BITS = 17;
	localparam int NUM_W     = ACC_W + FRAC_BITS;
	localparam int WS_W      = 29;
	localparam int FV_W      = 24;

	localparam int N3_MUL   = 683;
	localparam int N3_SHIFT = 11;

	localparam int DRAIN_CYC = 2;
	localparam int CNT_W     = 6;

	localparam logic [SHAPE_W-1:0] SHAPE_RST = 2'd2;
	localparam logic [TAPS_W-1:0]  TAPS_RST  = 9'd128;
	localparam logic [DECIM_W-1:0] DECIM_RST = 11'd32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SHAPE = 8'd0,
		CFG_TAPS  = 8'd1,
		CFG_DECIM = 8'd2
	} cfg_idx_t;

	typedef enum logic [SHAPE_W-1:0] {
		SHAPE_UNIFORM = 2'd0,
		SHAPE_TRI     = 2'd1,
		SHAPE_PARAB   = 2'd2
	} shape_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP1,
		S_PREP2,
		S_SCAN,
		S_DRAIN,
		S_DLOAD,
		S_DIV,
		S_FIN
	} state_t;

	typedef struct packed {
		logic push;
		logic prep_n3;
		logic prep_base;
		logic acc_clr;
		logic tap_en;
		logic div_load;
		logic div_step;
		logic finish;
	} cmd_t;

endpackage

/* sv/wfd_in_if.sv */
// Sample input channel: valid/ready handshake carrying one signed sample.
// Depends on nothing.
interface wfd_in_if #(
	parameter int SAMPLE_BITS = 8
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

/* sv/wfd_out_if.sv */
// Result output channel: valid/ready handshake carrying raw sum and normalized value.
// Depends on wfd_pkg for the field widths.
interface wfd_out_if;
	import wfd_pkg::*;

	logic                   valid;
	logic                   ready;
	logic signed [WS_W-1:0] weighted_sum;
	logic signed [FV_W-1:0] filtered_value;

	modport source (output valid, output weighted_sum, output filtered_value, input ready);
	modport sink (input valid, input weighted_sum, input filtered_value, output ready);
endinterface

/* sv/wfd_cfg_if.sv */
// Configuration write channel: valid/ready handshake carrying register index and data.
// Depends on wfd_pkg for the field widths.
interface wfd_cfg_if;
	import wfd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/wfd_ctrl.sv */
// Controller: phase counter, tap sequencer and divider step count for the decimator.
// Depends on wfd_pkg; drives the datapath wfd_dp through cmd_t.
module wfd_ctrl #(
	parameter int MAX_TAPS = wfd_pkg::MAX_TAPS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	input  logic [$clog2(MAX_TAPS+1)-1:0]           n,
	input  logic [wfd_pkg::DECIM_W-1:0]             d,
	output wfd_pkg::cmd_t                           cmd,
	output logic [$clog2(MAX_TAPS)-1:0]             tap
);
	import wfd_pkg::*;

	localparam int TW = $clog2(MAX_TAPS);
	localparam int NW = $clog2(MAX_TAPS + 1);

	state_t              state_q, state_d;
	logic [PHASE_W-1:0]  phase_q;
	logic [TW-1:0]       tap_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                out_valid_q;
	logic                accept;
	logic                wrap;

	assign accept    = in_valid && in_ready;
	assign wrap      = !(DECIM_W'(phase_q) + 1'b1 < d);
	assign tap       = tap_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			tap_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				phase_q <= wrap ? '0 : phase_q + 1'b1;
			end
			tap_q <= (state_q == S_SCAN) ? tap_q + 1'b1 : '0;
			cnt_q <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.push = accept;
				if (accept && wrap) state_d = S_PREP1;
			end
			S_PREP1: begin
				cmd.prep_n3 = 1'b1;
				state_d     = S_PREP2;
			end
			S_PREP2: begin
				cmd.prep_base = 1'b1;
				cmd.acc_clr   = 1'b1;
				state_d       = S_SCAN;
			end
			S_SCAN: begin
				cmd.tap_en = 1'b1;
				if (NW'(tap_q) == n - 1'b1) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (cnt_q == CNT_W'(DRAIN_CYC - 1)) state_d = S_DLOAD;
			end
			S_DLOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !out_valid_q || out_ready)
		else $error("result register overwritten while an item is pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pending result dropped");

	a_wrap_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && wrap |=> state_q == S_PREP1 && phase_q == '0)
		else $error("decimation period end did not start a pass");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && cnt_q == CNT_W'(NUM_W - 1) |=> state_q == S_FIN)
		else $error("divider ran the wrong number of steps");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> NW'(tap_q) < n)
		else $error("tap index beyond tap count");

endmodule

/* sv/wfd_dp.sv */
// Datapath: delay-line memory, window weight generator, MAC pipeline, restoring divider.
// Depends on wfd_pkg; sequenced by wfd_ctrl through cmd_t.
module wfd_dp #(
	parameter int MAX_TAPS    = wfd_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = wfd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wfd_pkg::cmd_t                         cmd,
	input  logic [$clog2(MAX_TAPS)-1:0]           tap,
	input  logic [wfd_pkg::SHAPE_W-1:0]           shape,
	input  logic [$clog2(MAX_TAPS+1)-1:0]         n,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	output logic signed [wfd_pkg::WS_W-1:0]       weighted_sum,
	output logic signed [wfd_pkg::FV_W-1:0]       filtered_value
);
	import wfd_pkg::*;

	localparam int TW = $clog2(MAX_TAPS);
	localparam int NW = $clog2(MAX_TAPS + 1);
	localparam int PW = SAMPLE_BITS + WT_W + 1;
	localparam logic signed [ACC_W-1:0] WS_HI = ACC_W'((64'sd1 <<< (WS_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] WS_LO = -ACC_W'(64'sd1 <<< (WS_W - 1));
	localparam logic [NUM_W-1:0]        Q_LIM = NUM_W'(64'd1 << (FV_W - 1));

	logic signed [SAMPLE_BITS-1:0] mem [MAX_TAPS];
	logic [TW-1:0]                 ptr_q, ptr_nx, rd_addr;
	logic [TW:0]                   rd_wide;
	logic [NW-1:0]                 fill_q;

	logic [NW-1:0]                 n3_q;
	logic [WT_W-1:0]               base_q;
	logic [NW+10:0]                n3_prod;
	logic [2*NW+1:0]               base_prod;

	logic [NW-1:0]                 tap_x, mirror, m;
	logic [2*NW+1:0]               sq;
	logic signed [NW+2:0]          dm, dn;
	logic signed [2*NW+5:0]        tail;
	logic [WT_W-1:0]               w;

	logic signed [SAMPLE_BITS-1:0] rd_s1;
	logic [WT_W-1:0]               w_s1, w_s2;
	logic                          en_s1, en_s2, live_s1;
	logic signed [PW-1:0]          prod_s2;
	logic signed [ACC_W-1:0]       acc_q;
	logic [TOT_W-1:0]              tot_q;

	logic [ACC_W-1:0]              mag;
	logic [NUM_W-1:0]              num_q, quo_q, qsat;
	logic [TOT_W:0]                den_q, rem_q;
	logic [TOT_W+1:0]              rem_sh;
	logic                          ge, neg_q, zero_q;

	assign ptr_nx  = (ptr_q == TW'(MAX_TAPS - 1)) ? '0 : ptr_q + 1'b1;
	assign rd_wide = (ptr_q >= tap) ? ({1'b0, ptr_q} - {1'b0, tap})
		: ({1'b0, ptr_q} + (TW+1)'(MAX_TAPS) - {1'b0, tap});
	assign rd_addr = rd_wide[TW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.push) mem[ptr_nx] <= sample;
		if (cmd.tap_en) rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (cmd.push) begin
			ptr_q <= ptr_nx;
			if (fill_q != NW'(MAX_TAPS)) fill_q <= fill_q + 1'b1;
		end
	end

	assign n3_prod   = (NW+11)'(n) * (NW+11)'(N3_MUL);
	assign base_prod = (2*NW+2)'(n3_q) * (2*NW+2)'(n3_q + 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.prep_n3) n3_q <= NW'(n3_prod >> N3_SHIFT) + 1'b1;
		if (cmd.prep_base) base_q <= WT_W'(base_prod >> 1);
	end

	always_comb begin
		tap_x  = NW'(tap);
		mirror = n - 1'b1 - tap_x;
		m      = (tap_x < mirror) ? tap_x : mirror;
		sq     = (2*NW+2)'(m) * (2*NW+2)'(m + 1'b1);
		dm     = signed'((NW+3)'(m)) - signed'((NW+3)'(n3_q));
		dn     = signed'((NW+3)'(n3_q) << 1) - (NW+3)'(1) - signed'((NW+3)'(m));
		tail   = (2*NW+6)'(dm) * (2*NW+6)'(dn);
		case (shape)
			SHAPE_TRI: w = (tap_x + 1'b1 <= (n >> 1)) ? WT_W'(tap_x) : WT_W'(n - tap_x);
			SHAPE_PARAB: begin
				if (m <= n3_q) w = WT_W'(sq >> 1);
				else w = base_q + WT_W'(tail);
			end
			default: w = WT_W'(1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
			en_s2 <= 1'b0;
		end else begin
			en_s1 <= cmd.tap_en;
			en_s2 <= en_s1;
		end
	end

	always_ff @(posedge clk) begin
		live_s1 <= tap_x < fill_q;
		w_s1    <= w;
		prod_s2 <= live_s1 ? PW'(rd_s1) * signed'({1'b0, w_s1}) : '0;
		w_s2    <= w_s1;
		if (cmd.acc_clr) begin
			acc_q <= '0;
			tot_q <= '0;
		end else if (en_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
			tot_q <= tot_q + TOT_W'(w_s2);
		end
	end

	assign mag    = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign qsat   = (quo_q > Q_LIM) ? Q_LIM : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q  <= (NUM_W'(mag) << FRAC_BITS) + NUM_W'(tot_q);
			den_q  <= {tot_q, 1'b0};
			rem_q  <= '0;
			quo_q  <= '0;
			neg_q  <= acc_q[ACC_W-1];
			zero_q <= tot_q == '0;
		end else if (cmd.div_step) begin
			num_q <= num_q << 1;
			rem_q <= ge ? (TOT_W+1)'(rem_sh - {1'b0, den_q}) : rem_sh[TOT_W:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
		if (cmd.finish) begin
			if (acc_q > WS_HI) weighted_sum <= WS_HI[WS_W-1:0];
			else if (acc_q < WS_LO) weighted_sum <= WS_LO[WS_W-1:0];
			else weighted_sum <= acc_q[WS_W-1:0];
			if (zero_q) filtered_value <= '0;
			else if (neg_q) filtered_value <= FV_W'(-qsat);
			else if (qsat == Q_LIM) filtered_value <= FV_W'(Q_LIM - 1'b1);
			else filtered_value <= FV_W'(qsat);
		end
	end

endmodule

/* sv/windowed_fir_decimator.sv */
// Top level of the windowed FIR decimator: configuration registers, controller, datapath.
// Depends on wfd_pkg, wfd_in_if, wfd_out_if, wfd_cfg_if, wfd_ctrl and wfd_dp.
//
//   channel   dir  payload                          accepted when
//   samples   in   sample                           valid && ready
//   results   out  weighted_sum, filtered_value     valid && ready
//   cfg       in   index, data                      valid && ready (ready always high)
//
// A sample that does not close a decimation period is accepted in the idle state; the next is taken at once.
// A closing sample holds off the next until its pass ends: the tap scan through the single delay-line
// read port, 57 steps of the bit-serial divider, and the PREP1, PREP2, DRAIN, DLOAD and FIN states.
// Reset clears the delay line through a fill count, so no clearing pass is needed.
// A result waits in the output register without blocking samples; the next pass holds before
// its final cycle until results.ready drains the waiting item.
module windowed_fir_decimator #(
	parameter int MAX_TAPS    = wfd_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = wfd_pkg::SAMPLE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	wfd_in_if.sink     samples,
	wfd_out_if.source  results,
	wfd_cfg_if.sink    cfg
);
	import wfd_pkg::*;

	localparam int TW = $clog2(MAX_TAPS);
	localparam int NW = $clog2(MAX_TAPS + 1);

	logic [SHAPE_W-1:0] shape_q;
	logic [TAPS_W-1:0]  taps_q;
	logic [DECIM_W-1:0] decim_q;
	logic [NW-1:0]      n;
	logic [DECIM_W-1:0] d;
	cmd_t               cmd;
	logic [TW-1:0]      tap;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= SHAPE_RST;
			taps_q  <= TAPS_RST;
			decim_q <= DECIM_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SHAPE: shape_q <= cfg.data[SHAPE_W-1:0];
				CFG_TAPS:  taps_q  <= cfg.data[TAPS_W-1:0];
				CFG_DECIM: decim_q <= cfg.data[DECIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(taps_q) > MAX_TAPS) n = NW'(MAX_TAPS);
		else if (taps_q < TAPS_W'(2)) n = NW'(2);
		else n = NW'(taps_q);
		if (decim_q == '0) d = DECIM_W'(1);
		else if (decim_q > DECIM_W'(DECIM_MAX)) d = DECIM_W'(DECIM_MAX);
		else d = decim_q;
	end

	wfd_ctrl #(
		.MAX_TAPS(MAX_TAPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.n        (n),
		.d        (d),
		.cmd      (cmd),
		.tap      (tap)
	);

	wfd_dp #(
		.MAX_TAPS   (MAX_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.tap           (tap),
		.shape         (shape_q),
		.n             (n),
		.sample        (samples.sample),
		.weighted_sum  (results.weighted_sum),
		.filtered_value(results.filtered_value)
	);

endmodule
